[rtl/ssbh_pkg.sv]
// ----------------------------------------------------------------------------
// ssbh_pkg
// Shared types and constants for the swept sphere against box hit test.
// ----------------------------------------------------------------------------
package ssbh_pkg;

  // number of spatial axes
  localparam int NUM_AXES = 3;

  // contact face codes of the grown box
  typedef enum logic [2:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

endpackage

[rtl/ssbh_sqrt.sv]
// ----------------------------------------------------------------------------
// ssbh_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module ssbh_sqrt #(
  parameter int W  = 16,
  parameter int SW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2*W-1:0]   in_val,
  input  logic [SW-1:0]    side,
  output logic             out_vld,
  output logic [W-1:0]     root,
  output logic [SW-1:0]    out_side
);
  import ssbh_pkg::*;

  localparam int IW = 2 * W;
  localparam int TW = 2 * W + 1;

  typedef struct packed {
    logic [IW-1:0] rem;
    logic [W-1:0]  root;
    logic [SW-1:0] side;
  } sq_t;

  sq_t        src     [W];
  sq_t        st_next [W];
  sq_t        st      [W];
  logic [W-1:0] vld;

  // one root bit per stage, remainder kept as value minus root squared
  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int I = W - 1 - j;

    if (j == 0) begin : g_first
      assign src[j] = '{rem: in_val, root: '0, side: side};
    end else begin : g_next
      assign src[j] = st[j-1];
    end

    always_comb begin
      logic [TW-1:0] term;
      term = (TW'(src[j].root) << (I + 1)) + (TW'(1) << (2 * I));
      st_next[j] = src[j];
      if (TW'(src[j].rem) >= term) begin
        st_next[j].rem     = src[j].rem - term[IW-1:0];
        st_next[j].root[I] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= st_next[j];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[W-2:0], in_vld};
    end
  end

  assign out_vld  = vld[W-1];
  assign root     = st[W-1].root;
  assign out_side = st[W-1].side;

endmodule

[rtl/ssbh_slab.sv]
// ----------------------------------------------------------------------------
// ssbh_slab
// Pipelined slab test: two stages per axis and a final overlap check with entry clamp.
// ----------------------------------------------------------------------------
module ssbh_slab #(
  parameter int W  = 16,
  parameter int SW = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_vld,
  input  logic [ssbh_pkg::NUM_AXES-1:0][W-1:0]  c,
  input  logic [ssbh_pkg::NUM_AXES-1:0][W-1:0]  m,
  input  logic [ssbh_pkg::NUM_AXES-1:0][W:0]    lo,
  input  logic [ssbh_pkg::NUM_AXES-1:0][W:0]    hi,
  input  logic [SW-1:0]                         side,
  output logic                                  out_vld,
  output logic [ssbh_pkg::NUM_AXES-1:0][W-1:0]  out_c,
  output logic [ssbh_pkg::NUM_AXES-1:0][W-1:0]  out_m,
  output logic [ssbh_pkg::NUM_AXES-1:0][W:0]    out_lo,
  output logic [ssbh_pkg::NUM_AXES-1:0][W:0]    out_hi,
  output logic [W-1:0]                          en_n,
  output logic [W-1:0]                          en_d,
  output logic                                  miss,
  output logic [SW-1:0]                         out_side
);
  import ssbh_pkg::*;

  localparam int NW = W + 2;
  localparam int PW = 2 * W + 3;
  localparam int NS = 2 * NUM_AXES + 2;

  typedef struct packed {
    logic                           miss;
    logic [NUM_AXES-1:0][W-1:0]     c;
    logic [NUM_AXES-1:0][W-1:0]     m;
    logic [NUM_AXES-1:0][W:0]       lo;
    logic [NUM_AXES-1:0][W:0]       hi;
    logic signed [NW-1:0]           en_n;
    logic [W-1:0]                   en_d;
    logic signed [NW-1:0]           ex_n;
    logic [W-1:0]                   ex_d;
    logic signed [NW-1:0]           a;
    logic signed [NW-1:0]           b;
    logic [W-1:0]                   d;
    logic signed [PW-1:0]           pa;
    logic signed [PW-1:0]           pb;
    logic signed [PW-1:0]           qa;
    logic signed [PW-1:0]           qb;
    logic [SW-1:0]                  side;
  } st_t;

  st_t           seed;
  st_t           st_next [NS];
  st_t           st      [NS];
  logic [NS-1:0] vld;

  // crossing distances of one axis, ordered, and the cross products
  function automatic st_t mul_step(st_t s, logic [1:0] ax);
    st_t                  r;
    logic signed [NW-1:0] av;
    logic signed [NW-1:0] bv;
    logic signed [NW-1:0] tv;
    logic signed [W:0]    mm;
    logic [W-1:0]         dv;
    r  = s;
    mm = $signed({s.m[ax][W-1], s.m[ax]});
    av = NW'($signed(s.lo[ax])) - NW'($signed(s.c[ax]));
    bv = NW'($signed(s.hi[ax])) - NW'($signed(s.c[ax]));
    if (mm < 0) begin
      av = -av;
      bv = -bv;
      dv = W'(-mm);
    end else begin
      dv = W'(mm);
    end
    if (av > bv) begin
      tv = av;
      av = bv;
      bv = tv;
    end
    r.a  = av;
    r.b  = bv;
    r.d  = dv;
    r.pa = PW'(av) * PW'($signed({1'b0, s.en_d}));
    r.pb = PW'(s.en_n) * PW'($signed({1'b0, dv}));
    r.qa = PW'(bv) * PW'($signed({1'b0, s.ex_d}));
    r.qb = PW'(s.ex_n) * PW'($signed({1'b0, dv}));
    return r;
  endfunction

  // narrow the entry/exit interval, or check the slab for a still axis
  function automatic st_t upd_step(st_t s, logic [1:0] ax);
    st_t r;
    r = s;
    if (s.m[ax] == '0) begin
      if (($signed(s.c[ax]) < $signed(s.lo[ax])) ||
          ($signed(s.c[ax]) > $signed(s.hi[ax]))) begin
        r.miss = 1'b1;
      end
    end else begin
      if (s.pa > s.pb) begin
        r.en_n = s.a;
        r.en_d = s.d;
      end
      if (s.qa < s.qb) begin
        r.ex_n = s.b;
        r.ex_d = s.d;
      end
    end
    return r;
  endfunction

  // cross products of the final entry and exit fractions
  function automatic st_t fin_mul(st_t s);
    st_t r;
    r    = s;
    r.pa = PW'(s.en_n) * PW'($signed({1'b0, s.ex_d}));
    r.pb = PW'(s.ex_n) * PW'($signed({1'b0, s.en_d}));
    return r;
  endfunction

  // empty interval check and clamp of the entry to 0..1
  function automatic st_t fin_upd(st_t s);
    st_t                  r;
    logic signed [NW-1:0] dn;
    r  = s;
    dn = NW'($signed({1'b0, s.en_d}));
    if (s.pa > s.pb) begin
      r.miss = 1'b1;
    end
    if (s.en_n < 0) begin
      r.en_n = '0;
    end else if (s.en_n > dn) begin
      r.en_n = dn;
    end
    return r;
  endfunction

  // starting interval 0..1
  always_comb begin
    seed      = '0;
    seed.c    = c;
    seed.m    = m;
    seed.lo   = lo;
    seed.hi   = hi;
    seed.en_d = W'(1);
    seed.ex_n = NW'(1);
    seed.ex_d = W'(1);
    seed.side = side;
  end

  // per axis stages
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    if (g == 0) begin : g_first
      assign st_next[2*g] = mul_step(seed, 2'(g));
    end else begin : g_next
      assign st_next[2*g] = mul_step(st[2*g-1], 2'(g));
    end
    assign st_next[2*g+1] = upd_step(st[2*g], 2'(g));
  end

  assign st_next[NS-2] = fin_mul(st[NS-3]);
  assign st_next[NS-1] = fin_upd(st[NS-2]);

  // stage registers
  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= st_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_vld};
    end
  end

  assign out_vld  = vld[NS-1];
  assign out_c    = st[NS-1].c;
  assign out_m    = st[NS-1].m;
  assign out_lo   = st[NS-1].lo;
  assign out_hi   = st[NS-1].hi;
  assign en_n     = st[NS-1].en_n[W-1:0];
  assign en_d     = st[NS-1].en_d;
  assign miss     = st[NS-1].miss;
  assign out_side = st[NS-1].side;

endmodule

[rtl/ssbh_div.sv]
// ----------------------------------------------------------------------------
// ssbh_div
// Pipelined restoring divider, several lanes over one shared divisor.
// ----------------------------------------------------------------------------
module ssbh_div #(
  parameter int DW = 17,
  parameter int QW = 18,
  parameter int NL = 4,
  parameter int SW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [NL-1:0][QW+DW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [SW-1:0]              side,
  output logic                       out_vld,
  output logic [NL-1:0][QW-1:0]      quo,
  output logic [SW-1:0]              out_side
);
  import ssbh_pkg::*;

  localparam int RW = QW + DW;

  typedef struct packed {
    logic [NL-1:0][RW-1:0] rem;
    logic [NL-1:0][QW-1:0] q;
    logic [DW-1:0]         den;
    logic [SW-1:0]         side;
  } dv_t;

  dv_t           src     [QW];
  dv_t           st_next [QW];
  dv_t           st      [QW];
  logic [QW-1:0] vld;

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;

    if (j == 0) begin : g_first
      assign src[j] = '{rem: num, q: '0, den: den, side: side};
    end else begin : g_next
      assign src[j] = st[j-1];
    end

    always_comb begin
      logic [RW-1:0] sh;
      sh         = RW'(src[j].den) << K;
      st_next[j] = src[j];
      for (int l = 0; l < NL; l++) begin
        if (src[j].rem[l] >= sh) begin
          st_next[j].rem[l]  = src[j].rem[l] - sh;
          st_next[j].q[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j] <= st_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_vld};
    end
  end

  assign out_vld  = vld[QW-1];
  assign quo      = st[QW-1].q;
  assign out_side = st[QW-1].side;

endmodule

[rtl/swept_sphere_box_hit.sv]
// Throughput: one query per cycle unless the pipeline holds; the square root and
//   divider each resolve one bit per pipeline stage, the slab test two per axis.
// The whole pipeline advances together; it holds when a result waits and
//   out_stall is high.
// Reset clears every valid bit, so the pipeline is empty after reset.
// ----------------------------------------------------------------------------
// swept_sphere_box_hit
// Swept sphere against axis aligned box: slab test on the box grown by the
// radius, with impact distance, contact point and nearest face.
// ----------------------------------------------------------------------------
module swept_sphere_box_hit #(
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_BITS-1:0]    center_x,
  input  logic [COORD_BITS-1:0]    center_y,
  input  logic [COORD_BITS-1:0]    center_z,
  input  logic [COORD_BITS-2:0]    radius,
  input  logic [COORD_BITS-1:0]    motion_x,
  input  logic [COORD_BITS-1:0]    motion_y,
  input  logic [COORD_BITS-1:0]    motion_z,
  input  logic [3*COORD_BITS-1:0]  box_low,
  input  logic [3*COORD_BITS-1:0]  box_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [COORD_BITS-1:0]    impact_time,
  output logic [COORD_BITS-1:0]    point_x,
  output logic [COORD_BITS-1:0]    point_y,
  output logic [COORD_BITS-1:0]    point_z,
  output ssbh_pkg::face_t          face
);
  import ssbh_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int QW  = W + 2;
  localparam int DW  = W + 1;
  localparam int RW  = QW + DW;
  localparam int PTW = W + 3;
  localparam int DSW = W + 4;

  localparam logic signed [PTW-1:0] P_MAX = PTW'(2 ** (W - 1) - 1);
  localparam logic signed [PTW-1:0] P_MIN = PTW'(-(2 ** (W - 1)));
  localparam logic signed [PTW-1:0] BIAS  = PTW'(2 ** W);

  typedef struct packed {
    logic [NUM_AXES-1:0][W-1:0] c;
    logic [NUM_AXES-1:0][W-1:0] m;
    logic [NUM_AXES-1:0][W:0]   lo;
    logic [NUM_AXES-1:0][W:0]   hi;
  } geo_t;

  typedef struct packed {
    logic                       miss;
    logic [NUM_AXES-1:0][W-1:0] c;
    logic [NUM_AXES-1:0][W:0]   lo;
    logic [NUM_AXES-1:0][W:0]   hi;
  } aux_t;

  logic adv;

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- front: grown box and squared motion length
  logic [NUM_AXES-1:0][W-1:0] in_c;
  logic [NUM_AXES-1:0][W-1:0] in_m;
  logic [NUM_AXES-1:0][W:0]   in_lo;
  logic [NUM_AXES-1:0][W:0]   in_hi;
  logic [2*W-1:0]             in_sumsq;

  always_comb begin
    logic signed [2*W-1:0] sq;
    in_c     = {center_z, center_y, center_x};
    in_m     = {motion_z, motion_y, motion_x};
    in_sumsq = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      in_lo[i] = (W+1)'($signed(box_low[i*W +: W])) - (W+1)'($signed({1'b0, radius}));
      in_hi[i] = (W+1)'($signed(box_high[i*W +: W])) + (W+1)'($signed({1'b0, radius}));
      sq       = (2*W)'($signed(in_m[i])) * (2*W)'($signed(in_m[i]));
      in_sumsq = in_sumsq + sq;
    end
  end

  logic           s1_vld;
  geo_t           s1_geo;
  logic [2*W-1:0] s1_sumsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_geo   <= '{c: in_c, m: in_m, lo: in_lo, hi: in_hi};
      s1_sumsq <= in_sumsq;
    end
  end

  // ---------------- motion length
  logic             sq_vld;
  logic [W-1:0]     sq_len;
  logic [$bits(geo_t)-1:0] sq_side;
  geo_t             sq_geo;

  ssbh_sqrt #(.W(W), .SW($bits(geo_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s1_vld),
    .in_val   (s1_sumsq),
    .side     (s1_geo),
    .out_vld  (sq_vld),
    .root     (sq_len),
    .out_side (sq_side)
  );

  assign sq_geo = geo_t'(sq_side);

  // ---------------- slab test
  logic                       sl_vld;
  logic [NUM_AXES-1:0][W-1:0] sl_c;
  logic [NUM_AXES-1:0][W-1:0] sl_m;
  logic [NUM_AXES-1:0][W:0]   sl_lo;
  logic [NUM_AXES-1:0][W:0]   sl_hi;
  logic [W-1:0]               sl_en_n;
  logic [W-1:0]               sl_en_d;
  logic                       sl_miss;
  logic [W-1:0]               sl_len;

  ssbh_slab #(.W(W), .SW(W)) u_slab (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (sq_vld),
    .c        (sq_geo.c),
    .m        (sq_geo.m),
    .lo       (sq_geo.lo),
    .hi       (sq_geo.hi),
    .side     (sq_len),
    .out_vld  (sl_vld),
    .out_c    (sl_c),
    .out_m    (sl_m),
    .out_lo   (sl_lo),
    .out_hi   (sl_hi),
    .en_n     (sl_en_n),
    .en_d     (sl_en_d),
    .miss     (sl_miss),
    .out_side (sl_len)
  );

  // ---------------- products of length and motion with the entry fraction
  logic                       mp_vld;
  logic [2*W-1:0]             mp_pt;
  logic [NUM_AXES-1:0][2*W:0] mp_pm;
  logic [W-1:0]               mp_e;
  aux_t                       mp_aux;

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_vld <= 1'b0;
    end else if (adv) begin
      mp_vld <= sl_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp_pt <= (2*W)'(sl_len) * (2*W)'(sl_en_n);
      for (int i = 0; i < NUM_AXES; i++) begin
        mp_pm[i] <= (2*W+1)'($signed(sl_m[i])) * (2*W+1)'($signed({1'b0, sl_en_n}));
      end
      mp_e   <= sl_en_d;
      mp_aux <= '{miss: sl_miss || (sl_len == '0), c: sl_c, lo: sl_lo, hi: sl_hi};
    end
  end

  // ---------------- biased rounding numerators: 2a + e + 2^W * 2e
  logic                     pn_vld;
  logic [NUM_AXES:0][RW-1:0] pn_num;
  logic [DW-1:0]            pn_den;
  aux_t                     pn_aux;
  logic [NUM_AXES:0][RW-1:0] num_next;

  always_comb begin
    logic signed [RW:0] t;
    num_next[0] = (RW'(mp_pt) << 1) + RW'(mp_e) + (RW'(mp_e) << (W + 1));
    for (int i = 0; i < NUM_AXES; i++) begin
      t = ((RW+1)'($signed(mp_pm[i])) <<< 1) + (RW+1)'(mp_e)
        + ((RW+1)'(mp_e) << (W + 1));
      num_next[i+1] = t[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pn_vld <= 1'b0;
    end else if (adv) begin
      pn_vld <= mp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pn_num <= num_next;
      pn_den <= {mp_e, 1'b0};
      pn_aux <= mp_aux;
    end
  end

  // ---------------- rounding divisions
  logic                      dv_vld;
  logic [NUM_AXES:0][QW-1:0] dv_q;
  logic [$bits(aux_t)-1:0]   dv_side;
  aux_t                      dv_aux;

  ssbh_div #(.DW(DW), .QW(QW), .NL(NUM_AXES + 1), .SW($bits(aux_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (pn_vld),
    .num      (pn_num),
    .den      (pn_den),
    .side     (pn_aux),
    .out_vld  (dv_vld),
    .quo      (dv_q),
    .out_side (dv_side)
  );

  assign dv_aux = aux_t'(dv_side);

  // ---------------- impact time and contact point
  logic                        f1_vld;
  logic                        f1_miss;
  logic [W-1:0]                f1_tm;
  logic [NUM_AXES-1:0][PTW-1:0] f1_p;
  logic [NUM_AXES-1:0][W:0]    f1_lo;
  logic [NUM_AXES-1:0][W:0]    f1_hi;
  logic [W-1:0]                tm_next;
  logic [NUM_AXES-1:0][PTW-1:0] p_next;

  always_comb begin
    logic signed [PTW-1:0] rt;
    logic signed [PTW-1:0] rp;
    rt = $signed({1'b0, dv_q[0]}) - BIAS;
    if (rt < 0) begin
      tm_next = '0;
    end else if (rt > PTW'(2 ** W - 1)) begin
      tm_next = '1;
    end else begin
      tm_next = rt[W-1:0];
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      rp        = $signed({1'b0, dv_q[i+1]}) - BIAS;
      p_next[i] = PTW'($signed(dv_aux.c[i])) + rp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_miss <= dv_aux.miss;
      f1_tm   <= tm_next;
      f1_p    <= p_next;
      f1_lo   <= dv_aux.lo;
      f1_hi   <= dv_aux.hi;
    end
  end

  // ---------------- face distances and saturated point
  logic                          f2_vld;
  logic                          f2_miss;
  logic [W-1:0]                  f2_tm;
  logic [NUM_AXES-1:0][W-1:0]    f2_ps;
  logic [2*NUM_AXES-1:0][DSW-1:0] f2_dist;
  logic [NUM_AXES-1:0][W-1:0]    ps_next;
  logic [2*NUM_AXES-1:0][DSW-1:0] dist_next;

  always_comb begin
    logic signed [DSW-1:0] dl;
    logic signed [DSW-1:0] dh;
    for (int i = 0; i < NUM_AXES; i++) begin
      if ($signed(f1_p[i]) > P_MAX) begin
        ps_next[i] = P_MAX[W-1:0];
      end else if ($signed(f1_p[i]) < P_MIN) begin
        ps_next[i] = P_MIN[W-1:0];
      end else begin
        ps_next[i] = f1_p[i][W-1:0];
      end
      dl = DSW'($signed(f1_p[i])) - DSW'($signed(f1_lo[i]));
      dh = DSW'($signed(f1_hi[i])) - DSW'($signed(f1_p[i]));
      dist_next[2*i]   = (dl < 0) ? DSW'(-dl) : DSW'(dl);
      dist_next[2*i+1] = (dh < 0) ? DSW'(-dh) : DSW'(dh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_vld <= 1'b0;
    end else if (adv) begin
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_miss <= f1_miss;
      f2_tm   <= f1_tm;
      f2_ps   <= ps_next;
      f2_dist <= dist_next;
    end
  end

  // ---------------- nearest face, first smallest wins
  face_t face_next;

  always_comb begin
    logic [DSW-1:0] best;
    best      = f2_dist[0];
    face_next = FACE_NEG_X;
    for (int k = 1; k < 2 * NUM_AXES; k++) begin
      if (f2_dist[k] < best) begin
        best      = f2_dist[k];
        face_next = face_t'(3'(k));
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (f2_miss) begin
        hit         <= 1'b0;
        impact_time <= '0;
        point_x     <= '0;
        point_y     <= '0;
        point_z     <= '0;
        face        <= FACE_NEG_X;
      end else begin
        hit         <= 1'b1;
        impact_time <= f2_tm;
        point_x     <= f2_ps[0];
        point_y     <= f2_ps[1];
        point_z     <= f2_ps[2];
        face        <= face_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a miss transaction carries all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (impact_time == '0 && point_x == '0 &&
      point_y == '0 && point_z == '0 && face == FACE_NEG_X))
    else $error("miss result with nonzero fields");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");
`endif

endmodule
